// File: hdl/double_ended_arena_allocator_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended arena allocator
// Shared property shorthands. They sample on clk and are off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_ARENA_ALLOCATOR_CORE_MACROS_SVH
`define DOUBLE_ENDED_ARENA_ALLOCATOR_CORE_MACROS_SVH

// A condition that must hold at every clock edge.
`define DEA_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("arena allocator invariant violated");

// A consequence that must hold in the same cycle as its trigger.
`define DEA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("arena allocator implication violated");

// A consequence that must hold in the cycle after its trigger.
`define DEA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arena allocator next-cycle check violated");

`endif

// File: hdl/dea_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended arena allocator package
// Command codes, default alignment and the word types shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dea_pkg;

  localparam int DATA_W            = 32;
  localparam int CMD_W             = 2;
  localparam int ALIGN_BYTES_DEF   = 8;

  localparam logic [CMD_W-1:0] CMD_PERSIST = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FRAME   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESET   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REINIT  = 2'd3;

  localparam logic CFG_REGION_BASE  = 1'b0;
  localparam logic CFG_REGION_BYTES = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] request_bytes;
  } req_t;

  typedef struct packed {
    logic              granted;
    logic [DATA_W-1:0] block_address;
    logic              out_of_memory;
    logic [DATA_W-1:0] persistent_used;
    logic [DATA_W-1:0] frame_used;
    logic [DATA_W-1:0] frame_peak;
    logic [DATA_W-1:0] bytes_available;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/dea_in_stage.sv
// ----------------------------------------------------------------------------
// Arena allocator input register
// Holds one request word until the execute stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dea_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dea_pkg::req_t in_word,
  input  wire logic          take,     // execute stage consumes the held word
  output logic               held_valid,
  output dea_pkg::req_t      held_word
);

  logic          vld_r;
  logic          vld_nxt;
  dea_pkg::req_t word_r;

  // The register refills in the same cycle it is drained.
  assign in_ready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end

  assign held_valid = vld_r;
  assign held_word  = word_r;

endmodule

`default_nettype wire

// File: hdl/dea_exec.sv
// ----------------------------------------------------------------------------
// Arena allocator execute stage
// Arena state registers and the combinational command logic.
// ----------------------------------------------------------------------------
`default_nettype none

`include "double_ended_arena_allocator_core_macros.svh"

module dea_exec #(
  parameter int ALIGN_BYTES = dea_pkg::ALIGN_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire dea_pkg::req_t              word,
  input  wire logic [dea_pkg::DATA_W-1:0] region_base,
  input  wire logic [dea_pkg::DATA_W-1:0] region_bytes,
  output dea_pkg::result_t                res
);

  localparam logic [dea_pkg::DATA_W-1:0] AMASK = dea_pkg::DATA_W'(ALIGN_BYTES - 1);

  logic [dea_pkg::DATA_W-1:0] base_r,   base_nxt;
  logic [dea_pkg::DATA_W-1:0] usable_r, usable_nxt;
  logic [dea_pkg::DATA_W-1:0] low_r,    low_nxt;
  logic [dea_pkg::DATA_W-1:0] high_r,   high_nxt;
  logic [dea_pkg::DATA_W-1:0] lowest_r, lowest_nxt;
  logic                       oom_r,    oom_nxt;

  logic [dea_pkg::DATA_W-1:0] gap;
  logic [dea_pkg::DATA_W-1:0] need;
  logic                       fits;
  logic [dea_pkg::DATA_W-1:0] skew;
  logic [dea_pkg::DATA_W-1:0] trimmed;
  logic                       bad_region;
  logic                       granted;
  logic [dea_pkg::DATA_W-1:0] addr;

  // The unrounded check comes first, so the rounding add can only wrap on
  // requests that are already rejected.
  assign gap  = high_r - low_r;
  assign need = (word.request_bytes + AMASK) & ~AMASK;
  assign fits = (word.request_bytes <= gap) && (need <= gap);

  assign skew       = (~region_base + 1'b1) & AMASK;
  assign trimmed    = (region_bytes - skew) & ~AMASK;
  assign bad_region = (region_base == '0) || (region_bytes == '0) || (skew >= region_bytes);

  always_comb begin
    base_nxt   = base_r;
    usable_nxt = usable_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    lowest_nxt = lowest_r;
    oom_nxt    = oom_r;
    granted    = 1'b0;
    addr       = '0;
    unique case (word.cmd)
      dea_pkg::CMD_PERSIST: begin
        if (fits) begin
          addr    = base_r + low_r;
          low_nxt = low_r + need;
          granted = 1'b1;
        end else begin
          oom_nxt = 1'b1;
        end
      end
      dea_pkg::CMD_FRAME: begin
        if (fits) begin
          high_nxt = high_r - need;
          if (high_nxt < lowest_r) begin
            lowest_nxt = high_nxt;
          end
          addr    = base_r + high_nxt;
          granted = 1'b1;
        end else begin
          oom_nxt = 1'b1;
        end
      end
      dea_pkg::CMD_RESET: begin
        high_nxt = usable_r;
        granted  = 1'b1;
      end
      dea_pkg::CMD_REINIT: begin
        low_nxt = '0;
        if (bad_region) begin
          base_nxt   = region_base;
          usable_nxt = '0;
          high_nxt   = '0;
          lowest_nxt = '0;
          oom_nxt    = 1'b1;
        end else begin
          base_nxt   = region_base + skew;
          usable_nxt = trimmed;
          high_nxt   = trimmed;
          lowest_nxt = trimmed;
          oom_nxt    = 1'b0;
          granted    = 1'b1;
        end
      end
      default: begin
        oom_nxt = oom_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      usable_r <= '0;
      low_r    <= '0;
      high_r   <= '0;
      lowest_r <= '0;
      oom_r    <= 1'b1;
    end else if (step) begin
      base_r   <= base_nxt;
      usable_r <= usable_nxt;
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      lowest_r <= lowest_nxt;
      oom_r    <= oom_nxt;
    end
  end

  // Usage figures are reported as they stand after the command.
  always_comb begin
    res.granted         = granted;
    res.block_address   = addr;
    res.out_of_memory   = oom_nxt;
    res.persistent_used = low_nxt;
    res.frame_used      = usable_nxt - high_nxt;
    res.frame_peak      = usable_nxt - lowest_nxt;
    res.bytes_available = high_nxt - low_nxt;
  end

  `DEA_ASSERT_ALWAYS(a_low_below_high, low_r <= high_r)
  `DEA_ASSERT_ALWAYS(a_high_in_region, (high_r <= usable_r) && (lowest_r <= usable_r))
  `DEA_ASSERT_ALWAYS(a_size_aligned, (usable_r & AMASK) == '0)
  `DEA_ASSERT_IMPL(a_refusal_flags_oom, step && !res.granted, res.out_of_memory)
  `DEA_ASSERT_NEXT(a_frame_reset_top, step && (word.cmd == dea_pkg::CMD_RESET), high_r == usable_r)

endmodule

`default_nettype wire

// File: hdl/double_ended_arena_allocator_core.sv
// Each request word passes through the input register and then the result register;
// a stalled result stream can hold it in the input register.
// Throughput: one request word per cycle while the result stream does not stall;
// the execute stage reads and updates the arena pointers for each command.
// Reset (synchronous, rst_n low): config registers clear, the arena is empty
// with the out-of-memory flag set, and both stream stages hold no word.
// ----------------------------------------------------------------------------
// Double-ended arena allocator core
// Two-ended bump allocator over one region: persistent blocks grow up from
// the low end, frame blocks grow down from the high end.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_arena_allocator_core #(
  parameter int ALIGN_BYTES = dea_pkg::ALIGN_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,

  // Configuration write channel. Index 0 is region_base, index 1 region_bytes.
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic                       cfg_index,
  input  wire logic [dea_pkg::DATA_W-1:0] cfg_data,

  // Request stream.
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [31:0]                in_tdata,  // [31:0] request_bytes
  input  wire logic [1:0]                 in_tuser,  // [1:0] cmd

  // Result stream.
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // [0] granted, [32:1] block_address, [33] out_of_memory,
  // [65:34] persistent_used, [97:66] frame_used, [129:98] frame_peak,
  // [161:130] bytes_available, [167:162] zero
  output logic [167:0]                    out_tdata
);

  // Configuration registers. They are read only by the reinit command, and software
  // must write them only while the block is idle; the block does not enforce it and has no hazard logic.
  logic [dea_pkg::DATA_W-1:0] region_base_r;
  logic [dea_pkg::DATA_W-1:0] region_bytes_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r  <= '0;
      region_bytes_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == dea_pkg::CFG_REGION_BASE) begin
        region_base_r <= cfg_data;
      end else begin
        region_bytes_r <= cfg_data;
      end
    end
  end

  // Input register. It drains whenever the result register can take a word,
  // so a stalled output only backs up into this one stage.
  dea_pkg::req_t in_word;
  dea_pkg::req_t held_word;
  logic          held_valid;
  logic          out_free;
  logic          step;
  logic          out_valid_r;

  assign in_word = {in_tuser, in_tdata};

  assign out_free = !out_valid_r || out_tready;
  assign step     = held_valid && out_free;

  dea_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_word    (in_word),
    .take       (step),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  // Execute stage: all pointer arithmetic for one command is combinational. The
  // arena state advances on the same edge that loads the result register, so
  // the next command sees the updated pointers without any forwarding.
  dea_pkg::result_t exec_res;

  dea_exec #(
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_exec (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .word         (held_word),
    .region_base  (region_base_r),
    .region_bytes (region_bytes_r),
    .res          (exec_res)
  );

  // Result register. It holds its word while the consumer stalls.
  logic             out_valid_nxt;
  dea_pkg::result_t out_res_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= exec_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0,
                       out_res_r.bytes_available,
                       out_res_r.frame_peak,
                       out_res_r.frame_used,
                       out_res_r.persistent_used,
                       out_res_r.out_of_memory,
                       out_res_r.block_address,
                       out_res_r.granted};

endmodule

`default_nettype wire

// File: tb/double_ended_arena_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// Testbench for the double-ended arena allocator core
// Streams allocation commands into the core and compares every result word
// with a cycle-free model of the arena kept inside the bench. It covers empty
// and trimmed regions, address wrap, huge requests and frame resets, with
// random stalls on both streams and one long back-pressure episode.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_arena_allocator_core_tb;
  import dea_pkg::*;

  localparam int          ALIGN       = ALIGN_BYTES_DEF;
  localparam logic [31:0] ALIGN_W     = ALIGN;
  localparam logic [31:0] ALIGN_M     = ALIGN - 1;
  localparam int          RAND_PHASES = 7;
  localparam int          PHASE_ITEMS = 100;
  localparam int          HOLD_CYCLES = 300;
  localparam int          STALL_LIMIT = 5000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;

  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = 1'b0;
  logic [31:0]  cfg_data = '0;

  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;   // [31:0] request_bytes
  logic [1:0]   in_tuser = '0;   // [1:0] cmd

  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // [0] granted, [32:1] block_address, [33] out_of_memory,
  // [65:34] persistent_used, [97:66] frame_used, [129:98] frame_peak,
  // [161:130] bytes_available, [167:162] zero
  logic [167:0] out_tdata;

  // Commands waiting to be offered; the head is the word on the bus.
  req_t         alloc_requests[$];
  // Results the arena model predicts, oldest first.
  result_t      predicted_replies[$];

  // Shadow of the configuration registers.
  logic [31:0]  reg_base = '0;
  logic [31:0]  reg_bytes = '0;

  // Arena model state, at its reset values: an empty arena with the flag set.
  logic [31:0]  arena_base = '0;
  logic [31:0]  arena_size = '0;
  logic [31:0]  low_off = '0;
  logic [31:0]  high_off = '0;
  logic [31:0]  high_floor = '0;
  logic         oom_sticky = 1'b1;

  int           mismatches = 0;
  int           gap_pct = 8;      // chance in percent that a side idles
  logic         hold_req = 1'b0;  // asks the receiver for one long hold-off
  int           hold_cnt;
  int           quiet_cycles;

  double_ended_arena_allocator_core #(
    .ALIGN_BYTES(ALIGN)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one command to the arena model and returns the result it implies.
  // Every figure in the result is taken after the command has taken effect.
  function automatic result_t arena_step(logic [1:0] cmd, logic [31:0] nbytes);
    result_t     r;
    logic [31:0] gap;
    logic [31:0] need;
    logic [31:0] skew;
    logic        ok;
    logic [31:0] addr;

    ok   = 1'b0;
    addr = '0;
    case (cmd)
      CMD_PERSIST, CMD_FRAME: begin
        gap = high_off - low_off;
        // The unrounded test comes first, so the rounding below cannot wrap
        // for any request that survives it.
        need = (nbytes + ALIGN_M) & ~ALIGN_M;
        if (nbytes > gap || need > gap) begin
          oom_sticky = 1'b1;
        end else if (cmd == CMD_PERSIST) begin
          addr    = arena_base + low_off;
          low_off = low_off + need;
          ok      = 1'b1;
        end else begin
          high_off = high_off - need;
          if (high_off < high_floor) high_floor = high_off;
          addr = arena_base + high_off;
          ok   = 1'b1;
        end
      end
      CMD_RESET: begin
        // The peak and the sticky flag survive a frame reset.
        high_off = arena_size;
        ok       = 1'b1;
      end
      default: begin
        skew       = (ALIGN_W - (reg_base & ALIGN_M)) & ALIGN_M;
        arena_base = reg_base;
        low_off    = '0;
        if (reg_base == '0 || reg_bytes == '0 || skew >= reg_bytes) begin
          // No usable region: the base stays unaligned and the arena is empty.
          arena_size = '0;
          high_off   = '0;
          high_floor = '0;
          oom_sticky = 1'b1;
        end else begin
          arena_base = reg_base + skew;
          arena_size = (reg_bytes - skew) & ~ALIGN_M;
          high_off   = arena_size;
          high_floor = arena_size;
          oom_sticky = 1'b0;
          ok         = 1'b1;
        end
      end
    endcase

    r.granted         = ok;
    r.block_address   = addr;
    r.out_of_memory   = oom_sticky;
    r.persistent_used = low_off;
    r.frame_used      = arena_size - high_off;
    r.frame_peak      = arena_size - high_floor;
    r.bytes_available = high_off - low_off;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, exp_v, act_v);
    end
  endfunction

  // Request driver. A word that is on the bus stays there until taken; a new
  // word is only put up after the previous one has gone or the bus was idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predicted_replies.push_back(arena_step(in_tuser, in_tdata));
        void'(alloc_requests.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (alloc_requests.size() != 0 && $urandom_range(99) >= gap_pct) begin
          in_tvalid <= 1'b1;
          in_tuser  <= alloc_requests[0].cmd;
          in_tdata  <= alloc_requests[0].request_bytes;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the monitor only has to look at
  // whether it is running.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req) begin
      hold_cnt <= HOLD_CYCLES;
      hold_req <= 1'b0;
    end
  end

  // Result monitor: unpacks each accepted word and checks it field by field
  // against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_cnt == 0) && ($urandom_range(99) >= gap_pct);
      if (out_tvalid && out_tready) begin
        if (predicted_replies.size() == 0) begin
          mismatches++;
          $error("result word arrived with no command outstanding");
        end else begin
          check_field("granted", 32'(predicted_replies[0].granted),
                      32'(out_tdata[0]));
          check_field("block_address", predicted_replies[0].block_address,
                      out_tdata[32:1]);
          check_field("out_of_memory", 32'(predicted_replies[0].out_of_memory),
                      32'(out_tdata[33]));
          check_field("persistent_used", predicted_replies[0].persistent_used,
                      out_tdata[65:34]);
          check_field("frame_used", predicted_replies[0].frame_used,
                      out_tdata[97:66]);
          check_field("frame_peak", predicted_replies[0].frame_peak,
                      out_tdata[129:98]);
          check_field("bytes_available", predicted_replies[0].bytes_available,
                      out_tdata[161:130]);
          void'(predicted_replies.pop_front());
        end
      end
    end
  end

  // Watchdog: ends the run when no channel moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_REGION_BASE) reg_base = val;
    else reg_bytes = val;
    @(negedge clk);
  endtask

  function automatic void offer_request(logic [1:0] cmd, logic [31:0] nbytes);
    req_t r;
    r.cmd           = cmd;
    r.request_bytes = nbytes;
    alloc_requests.push_back(r);
  endfunction

  // Waits until every command has been taken and answered. Each command
  // yields exactly one result.
  task automatic drain();
    while (alloc_requests.size() != 0 || predicted_replies.size() != 0)
      @(negedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  // Request sizes: mostly small so that both ends meet often, some spread
  // over the region, some fully random 32-bit values.
  function automatic logic [31:0] pick_bytes(logic [31:0] span);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 55) return $urandom_range(0, 48);
    else if (sel < 85) return $urandom_range(0, (span > 32'd4096) ? 4096 : span);
    else return $urandom;
  endfunction

  initial begin
    int unsigned sel;
    logic [31:0] span;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Out of reset the arena is empty with the flag set. A zero-byte request
    // is still granted there; anything larger fails.
    offer_request(CMD_PERSIST, 32'd0);
    offer_request(CMD_FRAME, 32'd0);
    offer_request(CMD_PERSIST, 32'd1);
    offer_request(CMD_RESET, 32'hFFFF_FFFF);
    offer_request(CMD_REINIT, 32'd0);
    drain();

    // Misaligned base: five bytes of skew, 256 usable bytes after trimming.
    write_reg(CFG_REGION_BASE, 32'h0000_1003);
    write_reg(CFG_REGION_BYTES, 32'h0000_0105);
    offer_request(CMD_REINIT, 32'd0);
    offer_request(CMD_PERSIST, 32'hFFFF_FFFF);  // huge, rejected before rounding
    offer_request(CMD_FRAME, 32'hFFFF_FFF9);
    offer_request(CMD_PERSIST, 32'd1);
    offer_request(CMD_FRAME, 32'd13);
    offer_request(CMD_FRAME, 32'd0);
    offer_request(CMD_PERSIST, 32'd232);        // takes the whole gap
    offer_request(CMD_PERSIST, 32'd0);          // granted with both ends met
    offer_request(CMD_FRAME, 32'd1);
    offer_request(CMD_RESET, 32'd0);
    offer_request(CMD_FRAME, 32'd9);
    drain();

    // Skew equal to the size leaves the arena empty; one more byte gives a
    // good reinit that trims to zero usable bytes.
    write_reg(CFG_REGION_BASE, 32'h0000_1001);
    write_reg(CFG_REGION_BYTES, 32'd7);
    offer_request(CMD_REINIT, 32'd0);
    drain();
    write_reg(CFG_REGION_BYTES, 32'd8);
    offer_request(CMD_REINIT, 32'd0);
    offer_request(CMD_PERSIST, 32'd0);
    drain();

    // Region at the very top of the address space: the aligned base wraps
    // to zero and frame addresses are computed modulo 2^32.
    write_reg(CFG_REGION_BASE, 32'hFFFF_FFF9);
    write_reg(CFG_REGION_BYTES, 32'hFFFF_FFFF);
    offer_request(CMD_REINIT, 32'd0);
    offer_request(CMD_FRAME, 32'h8000_0000);
    offer_request(CMD_PERSIST, 32'h7FFF_FFF0);
    drain();

    // Null base.
    write_reg(CFG_REGION_BASE, 32'd0);
    offer_request(CMD_REINIT, 32'd0);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        2: begin
          write_reg(CFG_REGION_BASE, 32'hFFFF_FFFF);
          write_reg(CFG_REGION_BYTES, 32'hFFFF_FFFF);
        end
        4: begin
          write_reg(CFG_REGION_BASE, 32'd0);
          write_reg(CFG_REGION_BYTES, $urandom_range(64, 4096));
        end
        5: begin
          write_reg(CFG_REGION_BASE, $urandom);
          write_reg(CFG_REGION_BYTES, $urandom_range(0, 15));
        end
        6: begin
          write_reg(CFG_REGION_BASE, $urandom);
          write_reg(CFG_REGION_BYTES, $urandom);
        end
        default: begin
          write_reg(CFG_REGION_BASE, $urandom);
          write_reg(CFG_REGION_BYTES, $urandom_range(64, 4096));
        end
      endcase
      span = (reg_bytes == '0) ? 32'd256 : reg_bytes;

      // Phase 1 runs without any idling; phase 3 carries the long hold-off
      // on the result side while requests keep coming.
      gap_pct = (p == 1) ? 0 : 8;
      if (p == 3) hold_req = 1'b1;

      offer_request(CMD_REINIT, $urandom);
      for (int i = 1; i < PHASE_ITEMS; i++) begin
        sel = $urandom_range(99);
        if (sel < 42) offer_request(CMD_PERSIST, pick_bytes(span));
        else if (sel < 82) offer_request(CMD_FRAME, pick_bytes(span));
        else if (sel < 93) offer_request(CMD_RESET, $urandom);
        else offer_request(CMD_REINIT, $urandom);
      end
      drain();
    end

    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
